// ----- hdl/rwlt_pkg.sv -----
`default_nettype none

package rwlt_pkg;

    // Request codes carried in the low bits of the input tdata.
    typedef enum logic [1:0] {
        OP_READ_ACQ  = 2'd0,
        OP_READ_REL  = 2'd1,
        OP_WRITE_ACQ = 2'd2,
        OP_WRITE_REL = 2'd3
    } op_t;

    // Outcome codes carried in the result tdata.
    typedef enum logic [1:0] {
        WHY_OK      = 2'd0,
        WHY_READERS = 2'd1,
        WHY_WRITER  = 2'd2,
        WHY_ERROR   = 2'd3
    } reason_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

endpackage : rwlt_pkg

`default_nettype wire

// ----- hdl/rwlt_ctrl.sv -----
`default_nettype none

module rwlt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire rwlt_pkg::dp_status_t status,
    output rwlt_pkg::dp_cmd_t        cmd
);
    import rwlt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready  = 1'b0;
        cmd.accept     = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.accept    = s_axis_tvalid;
            end
            ST_EXEC:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // An accepted request is always followed by its execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_EXEC))
        else $error("accepted request did not move to execute");

    // The clearing pass and a request never run together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_step && (cmd.accept || cmd.commit)))
        else $error("request overlapped the clearing pass");

endmodule : rwlt_ctrl

`default_nettype wire

// ----- hdl/rwlt_datapath.sv -----
`default_nettype none

module rwlt_datapath #(
    parameter int NUM_GROUPS         = 16,
    parameter int ENTRIES_PER_GROUP  = 64,
    parameter int READER_COUNT_WIDTH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [rwlt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire logic                                 s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [rwlt_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                      m_axis_tuser,
    input  wire rwlt_pkg::dp_cmd_t                    cmd,
    output rwlt_pkg::dp_status_t                      status
);
    import rwlt_pkg::*;

    localparam int DEPTH  = NUM_GROUPS * ENTRIES_PER_GROUP;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = READER_COUNT_WIDTH;
    localparam int WORD_W = CW + 1;

    // Entry word: writer mark on top, reader count below.
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic [3:0]        in_grp;
    logic [5:0]        in_ent;
    logic              in_range;
    logic [31:0]       slot_full;
    logic [ADDR_W-1:0] slot;

    op_t               op_reg;
    logic              dir_reg;
    logic              range_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_granted_reg;
    reason_t           out_reason_reg;
    logic              out_dir_reg;

    logic              wr_mark;
    logic [CW-1:0]     cnt;
    logic              granted;
    reason_t           reason;
    logic              new_mark;
    logic [CW-1:0]     new_cnt;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    assign in_grp    = s_axis_tdata[5:2];
    assign in_ent    = s_axis_tdata[11:6];
    assign in_range  = (32'(in_grp) < 32'(NUM_GROUPS))
                    && (32'(in_ent) < 32'(ENTRIES_PER_GROUP));
    assign slot_full = 32'(in_grp) * 32'(ENTRIES_PER_GROUP) + 32'(in_ent);
    assign slot      = slot_full[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= op_t'(s_axis_tdata[1:0]);
            dir_reg   <= s_axis_tuser;
            range_reg <= in_range;
            slot_reg  <= slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[slot];
        end
    end

    assign wr_mark = rd_data_reg[WORD_W-1];
    assign cnt     = rd_data_reg[CW-1:0];

    always_comb
    begin
        granted  = 1'b1;
        reason   = WHY_OK;
        new_mark = wr_mark;
        new_cnt  = cnt;
        if (!range_reg)
        begin
            granted = 1'b0;
            reason  = WHY_ERROR;
        end
        else
        begin
            case (op_reg)
                OP_READ_ACQ:
                begin
                    if (wr_mark)
                    begin
                        granted = 1'b0;
                        reason  = WHY_WRITER;
                    end
                    else if (&cnt)
                    begin
                        granted = 1'b0;
                        reason  = WHY_ERROR;
                    end
                    else
                    begin
                        new_cnt = cnt + CW'(1);
                    end
                end
                OP_READ_REL:
                begin
                    if (cnt == '0)
                    begin
                        granted = 1'b0;
                        reason  = WHY_ERROR;
                    end
                    else
                    begin
                        new_cnt = cnt - CW'(1);
                    end
                end
                OP_WRITE_ACQ:
                begin
                    if (cnt != '0)
                    begin
                        granted = 1'b0;
                        reason  = WHY_READERS;
                    end
                    else if (wr_mark)
                    begin
                        granted = 1'b0;
                        reason  = WHY_WRITER;
                    end
                    else
                    begin
                        new_mark = 1'b1;
                    end
                end
                OP_WRITE_REL:
                begin
                    new_mark = 1'b0;
                end
                default:
                begin
                    granted = 1'b0;
                    reason  = WHY_ERROR;
                end
            endcase
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = {new_mark, new_cnt};
        if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (cmd.commit && range_reg)
        begin
            mem_we = 1'b1;
        end
    end

    assign clr_addr_next     = cmd.clear_step ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;
    assign status.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign status.out_free   = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_granted_reg <= granted;
            out_reason_reg  <= reason;
            out_dir_reg     <= dir_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reason_reg, out_granted_reg};
    assign m_axis_tuser  = out_dir_reg;

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten");

    // A committed request always presents its result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    // A grant always carries the OK code, and only a grant does.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_granted_reg == (out_reason_reg == WHY_OK)))
        else $error("grant flag and reason disagree");

endmodule : rwlt_datapath

`default_nettype wire

// ----- hdl/inode_reader_writer_lock_table_top.sv -----
`default_nettype none

// Reader-writer lock table for inode entries, addressed by group and entry
// number. Each input transaction is one request (read acquire, read release,
// write acquire or write release) and produces exactly one result transaction
// carrying the grant flag, the reason code and an echo of the directory flag.
// For each request the block first reads the entry from the on-chip table
// into a registered output, then decides, writes the entry back and loads
// the result register. A new request is taken while a previous result is
// still waiting downstream; the block only stalls in its write-back cycle
// while the result register is still full. After reset the block clears its
// table, one entry per cycle, all NUM_GROUPS * ENTRIES_PER_GROUP entries (1024
// with the default values), and holds s_axis_tready low until that pass is
// done. Requests outside the configured group or entry range are denied with
// the error reason and leave the table untouched. Reader counts saturate: a
// read acquire at the maximum count or a read release at zero is denied with
// the error reason.

module inode_reader_writer_lock_table_top #(
    parameter int NUM_GROUPS         = 16,
    parameter int ENTRIES_PER_GROUP  = 64,
    parameter int READER_COUNT_WIDTH = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [1:0] operation, [5:2] group_index, [11:6] entry_index, [15:12] zero
    input  wire logic [rwlt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] is_directory
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] granted, [2:1] reason, [7:3] zero
    output logic [rwlt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] kind_is_directory
    output logic                                  m_axis_tuser
);
    import rwlt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences clearing, request acceptance and write-back.
    rwlt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // The datapath holds the lock table, the request registers, the decision
    // logic and the result register.
    rwlt_datapath #(
        .NUM_GROUPS         (NUM_GROUPS),
        .ENTRIES_PER_GROUP  (ENTRIES_PER_GROUP),
        .READER_COUNT_WIDTH (READER_COUNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .status        (status)
    );

endmodule : inode_reader_writer_lock_table_top

`default_nettype wire
